// File: rtl/lefu_pkg.sv
package lefu_pkg;

  // Ring and field geometry
  localparam int DEPTH   = 256;
  localparam int MAX_OUT = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CAP_W   = $clog2(DEPTH + 1);
  localparam int LIM_W   = $clog2(MAX_OUT);
  localparam int ML_W    = 7;
  localparam int CNT_W   = 9;
  localparam int FILL_W  = 8;

  localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);
  localparam logic [ML_W-1:0]  ML_MAX  = ML_W'(MAX_OUT);

  // Line terminators
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_LINE  = 2'd1,
    OP_COUNT = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_EMPTY_LINE = 3'd3,
    ST_NO_TERM    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CK_PUSH  = 2'd0,
    CK_LINE  = 2'd1,
    CK_COUNT = 2'd2
  } cmd_kind_e;

  // Classified command handed from front to back
  typedef struct packed {
    cmd_kind_e        kind;
    logic [7:0]       data;
    logic [LIM_W-1:0] lim;   // line: byte limit; count: min(count, limit)
  } cmd_t;

  // One result item
  typedef struct packed {
    status_e           status;
    logic [7:0]        byte_out;
    logic              byte_valid;
    logic              last;
    logic [FILL_W-1:0] fill_level;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_SCAN_RD,
    BK_SCAN_CHK,
    BK_DRN_RD,
    BK_DRN_OUT
  } back_state_e;

endpackage

// File: rtl/lefu_front.sv
module lefu_front (
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [23:0]       s_axis_tdata_i,  // byte_in[7:0], count[16:8], max_len[23:17]
  input  logic [1:0]        s_axis_tuser_i,  // opcode[1:0]
  input  logic              q_full_i,
  output logic              q_push_o,
  output lefu_pkg::cmd_t    q_cmd_o
);
  import lefu_pkg::*;

  logic [7:0]       byte_in;
  logic [CNT_W-1:0] count;
  logic [ML_W-1:0]  max_len;
  logic [ML_W-1:0]  ml_clamped;
  logic [LIM_W-1:0] limit;
  opcode_e          opcode;

  assign byte_in = s_axis_tdata_i[7:0];
  assign count   = s_axis_tdata_i[16:8];
  assign max_len = s_axis_tdata_i[23:17];
  assign opcode  = opcode_e'(s_axis_tuser_i);

  // Accept whenever the queue has room; unused opcodes are dropped here
  assign s_axis_tready_o = !q_full_i;
  assign q_push_o = s_axis_tvalid_i && !q_full_i && (opcode != OP_RSVD);

  // Clamp destination size to 1..MAX_OUT and derive the byte limit
  always_comb begin
    if (max_len == '0) begin
      ml_clamped = ML_W'(1);
    end else if (max_len > ML_MAX) begin
      ml_clamped = ML_MAX;
    end else begin
      ml_clamped = max_len;
    end
  end

  assign limit = LIM_W'(ml_clamped - ML_W'(1));

  // Classify into a command for the back end
  always_comb begin
    q_cmd_o.data = byte_in;
    q_cmd_o.lim  = limit;
    case (opcode)
      OP_PUSH: q_cmd_o.kind = CK_PUSH;
      OP_LINE: q_cmd_o.kind = CK_LINE;
      OP_COUNT: begin
        q_cmd_o.kind = CK_COUNT;
        if (count < {{(CNT_W-LIM_W){1'b0}}, limit}) begin
          q_cmd_o.lim = LIM_W'(count);
        end
      end
      default: q_cmd_o.kind = CK_PUSH;
    endcase
  end

endmodule

// File: rtl/lefu_cmd_fifo.sv
module lefu_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lefu_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output lefu_pkg::cmd_t cmd_o
);
  import lefu_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: rtl/lefu_back.sv
module lefu_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lefu_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                       cq_valid_i,
  input  lefu_pkg::cmd_t             cq_cmd_i,
  output logic                       cq_pop_o,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output lefu_pkg::res_t             res_o
);
  import lefu_pkg::*;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] p,
                                                input logic [IDX_W-1:0] n,
                                                input logic [CAP_W-1:0] c);
    logic [CAP_W:0] s;
    s = {2'b00, p} + {2'b00, n};
    if (s >= {1'b0, c}) begin
      s = s - {1'b0, c};
    end
    return s[IDX_W-1:0];
  endfunction

  back_state_e       state_q, state_d;
  logic [CAP_W-1:0]  cap_q;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]  wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [IDX_W-1:0]  scan_q, scan_d;
  logic [LIM_W-1:0]  len_q, len_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  cmd_t              cmd_q, cmd_d;
  res_t              res_q, res_d;
  logic              ov_q, ov_d;

  logic [7:0]        ring [DEPTH];
  logic [7:0]        rdata_q;
  logic              mem_we;

  logic [CAP_W-1:0]  cfg_cap;
  logic [FILL_W-1:0] fill;
  logic              full;
  logic              term;
  logic              out_free;
  logic [IDX_W-1:0]  scan_nxt;
  logic [IDX_W-1:0]  cnt_len;
  logic [IDX_W-1:0]  line_len;
  logic [IDX_W-1:0]  lim_ext;

  // Derived ring status
  assign fill = (wr_idx_q >= rd_idx_q)
              ? FILL_W'(wr_idx_q - rd_idx_q)
              : FILL_W'({1'b0, wr_idx_q} + cap_q - {1'b0, rd_idx_q});
  assign full     = ({1'b0, fill} >= (cap_q - CAP_W'(1)));
  assign term     = (rdata_q == CH_LF) || (rdata_q == CH_CR);
  assign out_free = !ov_q || m_axis_tready_i;
  assign scan_nxt = scan_q + IDX_W'(1);
  assign lim_ext  = {{(IDX_W-LIM_W){1'b0}}, cmd_q.lim};
  assign cnt_len  = (lim_ext < fill) ? lim_ext : fill;
  assign line_len = (scan_nxt < lim_ext) ? scan_nxt : lim_ext;

  always_comb begin
    if (cfg_wdata_i < CAP_MIN) begin
      cfg_cap = CAP_MIN;
    end else if (cfg_wdata_i > CAP_MAX) begin
      cfg_cap = CAP_MAX;
    end else begin
      cfg_cap = cfg_wdata_i;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cq_valid_i) state_d = BK_EXEC;
      end
      BK_EXEC: begin
        if (cmd_q.kind == CK_PUSH || fill == '0) begin
          if (out_free) state_d = BK_IDLE;
        end else if (cmd_q.kind == CK_LINE) begin
          state_d = BK_SCAN_RD;
        end else if (cnt_len == '0) begin
          if (out_free) state_d = BK_IDLE;
        end else begin
          state_d = BK_DRN_RD;
        end
      end
      BK_SCAN_RD: state_d = BK_SCAN_CHK;
      BK_SCAN_CHK: begin
        if (term) begin
          if (scan_q == '0 || line_len == '0) begin
            if (out_free) state_d = BK_IDLE;
          end else begin
            state_d = BK_DRN_RD;
          end
        end else if (scan_nxt == fill) begin
          if (out_free) state_d = BK_IDLE;
        end else begin
          state_d = BK_SCAN_RD;
        end
      end
      BK_DRN_RD: state_d = BK_DRN_OUT;
      BK_DRN_OUT: begin
        if (out_free) begin
          state_d = (len_q == LIM_W'(1)) ? BK_IDLE : BK_DRN_RD;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and result loading
  always_comb begin
    rd_idx_d = rd_idx_q;
    wr_idx_d = wr_idx_q;
    ptr_d    = ptr_q;
    scan_d   = scan_q;
    len_d    = len_q;
    fill_d   = fill_q;
    cmd_d    = cmd_q;
    res_d    = res_q;
    ov_d     = ov_q && !m_axis_tready_i;
    mem_we   = 1'b0;
    cq_pop_o = 1'b0;

    case (state_q)
      BK_IDLE: begin
        if (cq_valid_i) begin
          cq_pop_o = 1'b1;
          cmd_d    = cq_cmd_i;
        end
      end
      BK_EXEC: begin
        if (cmd_q.kind == CK_PUSH) begin
          if (out_free) begin
            ov_d             = 1'b1;
            res_d.byte_out   = '0;
            res_d.byte_valid = 1'b0;
            res_d.last       = 1'b1;
            if (full) begin
              res_d.status     = ST_FULL;
              res_d.fill_level = fill;
            end else begin
              mem_we           = 1'b1;
              wr_idx_d         = wrap_add(wr_idx_q, IDX_W'(1), cap_q);
              res_d.status     = ST_OK;
              res_d.fill_level = fill + FILL_W'(1);
            end
          end
        end else if (fill == '0) begin
          if (out_free) begin
            ov_d  = 1'b1;
            res_d = '{status: ST_EMPTY, byte_out: '0, byte_valid: 1'b0,
                      last: 1'b1, fill_level: '0};
          end
        end else if (cmd_q.kind == CK_LINE) begin
          scan_d = '0;
          ptr_d  = rd_idx_q;
        end else if (cnt_len == '0) begin
          if (out_free) begin
            ov_d  = 1'b1;
            res_d = '{status: ST_OK, byte_out: '0, byte_valid: 1'b0,
                      last: 1'b1, fill_level: fill};
          end
        end else begin
          len_d    = LIM_W'(cnt_len);
          ptr_d    = rd_idx_q;
          fill_d   = fill - cnt_len;
          rd_idx_d = wrap_add(rd_idx_q, cnt_len, cap_q);
        end
      end
      BK_SCAN_CHK: begin
        if (term) begin
          if (scan_q == '0) begin
            // leading terminator: drop it, report an empty line
            if (out_free) begin
              ov_d     = 1'b1;
              rd_idx_d = wrap_add(rd_idx_q, IDX_W'(1), cap_q);
              res_d    = '{status: ST_EMPTY_LINE, byte_out: '0, byte_valid: 1'b0,
                           last: 1'b1, fill_level: fill - FILL_W'(1)};
            end
          end else if (line_len == '0) begin
            if (out_free) begin
              ov_d  = 1'b1;
              res_d = '{status: ST_OK, byte_out: '0, byte_valid: 1'b0,
                        last: 1'b1, fill_level: fill};
            end
          end else begin
            len_d    = LIM_W'(line_len);
            ptr_d    = rd_idx_q;
            fill_d   = fill - line_len;
            rd_idx_d = wrap_add(rd_idx_q, line_len, cap_q);
          end
        end else if (scan_nxt == fill) begin
          if (out_free) begin
            ov_d  = 1'b1;
            res_d = '{status: ST_NO_TERM, byte_out: '0, byte_valid: 1'b0,
                      last: 1'b1, fill_level: fill};
          end
        end else begin
          scan_d = scan_nxt;
          ptr_d  = wrap_add(ptr_q, IDX_W'(1), cap_q);
        end
      end
      BK_DRN_OUT: begin
        if (out_free) begin
          ov_d  = 1'b1;
          res_d = '{status: ST_OK, byte_out: rdata_q, byte_valid: 1'b1,
                    last: (len_q == LIM_W'(1)), fill_level: fill_q};
          len_d = len_q - LIM_W'(1);
          ptr_d = wrap_add(ptr_q, IDX_W'(1), cap_q);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers; a capacity write empties the ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      cap_q    <= CAP_MAX;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      ptr_q    <= '0;
      scan_q   <= '0;
      len_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      scan_q  <= scan_d;
      len_q   <= len_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        cap_q    <= cfg_cap;
        rd_idx_q <= '0;
        wr_idx_q <= '0;
      end else begin
        rd_idx_q <= rd_idx_d;
        wr_idx_q <= wr_idx_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    cmd_q  <= cmd_d;
    res_q  <= res_d;
  end

  // Byte ring: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring[wr_idx_q] <= cmd_q.data;
    end
    rdata_q <= ring[ptr_q];
  end

  assign m_axis_tvalid_o = ov_q;
  assign res_o           = res_q;

  a_idx_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, rd_idx_q} < cap_q) && ({1'b0, wr_idx_q} < cap_q))
    else $error("ring index beyond capacity");

  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q >= CAP_MIN) && (cap_q <= CAP_MAX))
    else $error("capacity out of range");

  a_drain_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DRN_RD || state_q == BK_DRN_OUT) |-> (len_q != '0))
    else $error("drain with zero length");

  a_nobyte_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !res_q.byte_valid) |-> res_q.last)
    else $error("byteless result not marked last");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SCAN_CHK) |-> (scan_q < fill))
    else $error("line scan past fill level");

endmodule

// File: rtl/line_extracting_byte_fifo_unit.sv
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata: byte_in, count, max_len; tuser: opcode
// m_axis    out  m_axis_tvalid/tready        tdata: byte_out, fill_level;
//                                            tuser: status, byte_valid; tlast: last
// cfg       in   cfg_we (no stall)           cfg_wdata: capacity_in_use
//
// Push runs through idle and exec states; pop-count adds a read and an output state per
// removed byte; pop-line adds a read and a check state per byte scanned up to the
// terminator, then a read and output state per emitted byte (one registered ring read port).
// Reset empties the ring and sets capacity to 256; no clearing pass is run.
// A two-entry command queue lets input items enter while the back end works or its
// output register waits on m_axis_tready.
module line_extracting_byte_fifo_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,      // capacity_in_use[8:0]
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // byte_in[7:0], count[16:8], max_len[23:17]
  input  logic [1:0]  s_axis_tuser_i,   // opcode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // byte_out[7:0], fill_level[15:8]
  output logic [3:0]  m_axis_tuser_o,   // status[2:0], byte_valid[3]
  output logic        m_axis_tlast_o
);
  import lefu_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  cmd_t front_cmd, queue_cmd;
  res_t res;

  // Classify incoming items
  lefu_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (front_cmd)
  );

  // Decouple front and back
  lefu_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (queue_cmd)
  );

  // Execute against the ring
  lefu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cq_valid_i      (q_valid),
    .cq_cmd_i        (queue_cmd),
    .cq_pop_o        (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .res_o           (res)
  );

  // Pack result fields
  assign m_axis_tdata_o = {res.fill_level, res.byte_out};
  assign m_axis_tuser_o = {res.byte_valid, res.status};
  assign m_axis_tlast_o = res.last;

endmodule
